@@ src/spe_pkg.sv @@
// ----------------------------------------------------------------------------
// spe_pkg
// Shared constants and elaboration-time helpers for the sun position unit.
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam int ANGLE_BITS_DEF    = 32;
    localparam int DAY_FRAC_BITS_DEF = 20;
    localparam int CORDIC_STAGES_DEF = 30;

    // Q3.60 for e, sines, cosines and vector parts
    localparam int VFRAC   = 60;
    localparam int MUL_LAT = 4;

    localparam logic [63:0] ONE    = 64'h1000_0000_0000_0000;
    localparam logic [63:0] SIGN   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] QUART  = 64'h4000_0000_0000_0000;
    localparam logic [63:0] INV2PI = 64'h28BE_60DB_9391_054A;

    // Long division of num/den into a binary fraction, truncated.
    function automatic logic [63:0] bin_frac(input logic [63:0] num,
                                             input logic [63:0] den,
                                             input int bits);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = num;
        for (int i = 0; i < bits; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // Restoring division, used for constants only.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, dv})
            begin
                r    = r - {1'b0, dv};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] amask(input int angle_bits);
        return ~64'd0 << (64 - angle_bits);
    endfunction

    // atan(2^-i) in turns; series in 2^-63 rad units, then scaled by 1/(2 pi)
    function automatic logic [63:0] atan_turn(input int i, input int angle_bits);
        logic [63:0]  s;
        logic [63:0]  t;
        logic [127:0] p;
        int           sh;
        if (i == 0)
        begin
            return 64'd1 << 61;
        end
        s = '0;
        for (int k = 0; k < 64; k++)
        begin
            sh = i * (2 * k + 1);
            if (sh < 64)
            begin
                t = udiv64(SIGN >> sh, 64'(2 * k + 1));
                s = ((k & 1) != 0) ? s - t : s + t;
            end
        end
        p = {64'd0, s} * {64'd0, INV2PI};
        return p[126:63] & amask(angle_bits);
    endfunction

    localparam logic [63:0] C_W0   = bin_frac(64'd2829404, 64'd3600000, 64);
    localparam logic [63:0] C_M0   = bin_frac(64'd3560470, 64'd3600000, 64);
    localparam logic [63:0] C_O0   = bin_frac(64'd234393, 64'd3600000, 64);
    localparam logic [63:0] C_KW   = bin_frac(64'd470935, 64'd3600000000000, 64);
    localparam logic [63:0] C_KM   = bin_frac(64'd9856002585, 64'd3600000000000, 64);
    localparam logic [63:0] C_KO   = bin_frac(64'd3563, 64'd3600000000000, 64);
    localparam logic [63:0] C_E0   = bin_frac(64'd16709, 64'd1000000, VFRAC);
    localparam logic [63:0] C_KE   = bin_frac(64'd1151, 64'd1000000000000, 64);
    localparam logic [63:0] C_KINV = bin_frac(64'd607252935008881256,
                                              64'd1000000000000000000, VFRAC);

endpackage

@@ src/spe_if.sv @@
// ----------------------------------------------------------------------------
// spe_if
// Valid/ready channels: day offset in, sun position out.
// ----------------------------------------------------------------------------
interface spe_day_if;
    logic               valid;
    logic               ready;
    logic signed [35:0] day_offset;

    modport source (output valid, output day_offset, input ready);
    modport sink (input valid, input day_offset, output ready);
endinterface

interface spe_pos_if;
    logic               valid;
    logic               ready;
    logic        [31:0] right_ascension;
    logic signed [31:0] declination;
    logic        [31:0] subsolar_longitude;

    modport source (output valid, output right_ascension, output declination,
                    output subsolar_longitude, input ready);
    modport sink (input valid, input right_ascension, input declination,
                  input subsolar_longitude, output ready);
endinterface

@@ src/spe_dly.sv @@
// ----------------------------------------------------------------------------
// spe_dly
// Enabled delay line that keeps side values aligned with the pipeline.
// ----------------------------------------------------------------------------
module spe_dly #(
    parameter int W = 64,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    generate
        if (D == 0)
        begin : g_wire
            assign q = d;
        end
        else
        begin : g_line
            logic [W-1:0] tap_reg [0:D-1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    for (int i = 0; i < D; i++)
                    begin
                        tap_reg[i] <= '0;
                    end
                end
                else if (en)
                begin
                    tap_reg[0] <= d;
                    for (int i = 1; i < D; i++)
                    begin
                        tap_reg[i] <= tap_reg[i-1];
                    end
                end
            end

            assign q = tap_reg[D-1];
        end
    endgenerate

endmodule

@@ src/spe_mul.sv @@
// ----------------------------------------------------------------------------
// spe_mul
// Sign-magnitude 64x64 multiply, truncated shift, four stages.
// ----------------------------------------------------------------------------
module spe_mul #(
    parameter int SH = spe_pkg::VFRAC
) (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0]  am_reg;
    logic [63:0]  bm_reg;
    logic [2:0]   neg_reg;
    logic [63:0]  p00_reg;
    logic [63:0]  p01_reg;
    logic [63:0]  p10_reg;
    logic [63:0]  p11_reg;
    logic [127:0] sum_reg;
    logic [127:0] sum_sh;
    logic [63:0]  p_reg;

    assign sum_sh = sum_reg >> SH;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am_reg     <= a[63] ? 64'd0 - a : a;
            bm_reg     <= b[63] ? 64'd0 - b : b;
            neg_reg[0] <= a[63] ^ b[63];

            // 32x32 partial products
            p00_reg    <= {32'd0, am_reg[31:0]} * {32'd0, bm_reg[31:0]};
            p01_reg    <= {32'd0, am_reg[31:0]} * {32'd0, bm_reg[63:32]};
            p10_reg    <= {32'd0, am_reg[63:32]} * {32'd0, bm_reg[31:0]};
            p11_reg    <= {32'd0, am_reg[63:32]} * {32'd0, bm_reg[63:32]};
            neg_reg[1] <= neg_reg[0];

            sum_reg    <= {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                        + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};
            neg_reg[2] <= neg_reg[1];

            p_reg      <= neg_reg[2] ? 64'd0 - sum_sh[63:0] : sum_sh[63:0];
        end
    end

    assign p = p_reg;

endmodule

@@ src/spe_rot.sv @@
// ----------------------------------------------------------------------------
// spe_rot
// Unrolled circular CORDIC in rotation mode: cos and sin of a turn angle.
// ----------------------------------------------------------------------------
module spe_rot #(
    parameter int ANGLE_BITS = spe_pkg::ANGLE_BITS_DEF,
    parameter int STAGES     = spe_pkg::CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] ang,
    output logic [63:0] c,
    output logic [63:0] s
);

    logic [63:0]     x_reg [0:STAGES];
    logic [63:0]     y_reg [0:STAGES];
    logic [63:0]     z_reg [0:STAGES];
    logic [STAGES:0] flip_reg;
    logic [63:0]     x_next [1:STAGES];
    logic [63:0]     y_next [1:STAGES];
    logic [63:0]     z_next [1:STAGES];
    logic [63:0]     ang_q;
    logic [63:0]     c_reg;
    logic [63:0]     s_reg;

    // left half plane: rotate by half a turn, negate at the end
    assign ang_q = ang + spe_pkg::QUART;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= spe_pkg::C_KINV;
            y_reg[0]    <= '0;
            z_reg[0]    <= ang_q[63] ? ang + spe_pkg::SIGN : ang;
            flip_reg[0] <= ang_q[63];
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic [63:0] ATAN = spe_pkg::atan_turn(i, ANGLE_BITS);
        logic [63:0] dx;
        logic [63:0] dy;

        assign dx = $signed(y_reg[i]) >>> i;
        assign dy = $signed(x_reg[i]) >>> i;

        always_comb
        begin
            if (z_reg[i][63])
            begin
                x_next[i+1] = x_reg[i] + dx;
                y_next[i+1] = y_reg[i] - dy;
                z_next[i+1] = z_reg[i] + ATAN;
            end
            else
            begin
                x_next[i+1] = x_reg[i] - dx;
                y_next[i+1] = y_reg[i] + dy;
                z_next[i+1] = z_reg[i] - ATAN;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next[i+1];
                y_reg[i+1]    <= y_next[i+1];
                z_reg[i+1]    <= z_next[i+1];
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= flip_reg[STAGES] ? 64'd0 - x_reg[STAGES] : x_reg[STAGES];
            s_reg <= flip_reg[STAGES] ? 64'd0 - y_reg[STAGES] : y_reg[STAGES];
        end
    end

    assign c = c_reg;
    assign s = s_reg;

endmodule

@@ src/spe_vec.sv @@
// ----------------------------------------------------------------------------
// spe_vec
// Unrolled circular CORDIC in vectoring mode: atan2 in turns and magnitude.
// ----------------------------------------------------------------------------
module spe_vec #(
    parameter int ANGLE_BITS = spe_pkg::ANGLE_BITS_DEF,
    parameter int STAGES     = spe_pkg::CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] x,
    input  logic [63:0] y,
    output logic [63:0] ang,
    output logic [63:0] mag
);

    logic [63:0] x_reg [0:STAGES];
    logic [63:0] y_reg [0:STAGES];
    logic [63:0] z_reg [0:STAGES];
    logic [63:0] x_next [1:STAGES];
    logic [63:0] y_next [1:STAGES];
    logic [63:0] z_next [1:STAGES];

    // negative x: mirror through the origin and start at half a turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x[63] ? 64'd0 - x : x;
            y_reg[0] <= x[63] ? 64'd0 - y : y;
            z_reg[0] <= x[63] ? spe_pkg::SIGN : 64'd0;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic [63:0] ATAN = spe_pkg::atan_turn(i, ANGLE_BITS);
        logic [63:0] dx;
        logic [63:0] dy;

        assign dx = $signed(y_reg[i]) >>> i;
        assign dy = $signed(x_reg[i]) >>> i;

        always_comb
        begin
            if (y_reg[i][63])
            begin
                x_next[i+1] = x_reg[i] - dx;
                y_next[i+1] = y_reg[i] + dy;
                z_next[i+1] = z_reg[i] - ATAN;
            end
            else
            begin
                x_next[i+1] = x_reg[i] + dx;
                y_next[i+1] = y_reg[i] - dy;
                z_next[i+1] = z_reg[i] + ATAN;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1] <= x_next[i+1];
                y_reg[i+1] <= y_next[i+1];
                z_reg[i+1] <= z_next[i+1];
            end
        end
    end

    assign ang = z_reg[STAGES];
    assign mag = x_reg[STAGES];

endmodule

@@ src/sun_position_ephemeris_unit.sv @@
// ----------------------------------------------------------------------------
// sun_position_ephemeris_unit
// Sun right ascension, declination and sub-solar longitude from a day offset.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                           handshake
//  day_ch   in   day_offset (s36, 20 frac bits)                    valid/ready
//  pos_ch   out  right_ascension, declination, subsolar_longitude  valid/ready
//
//  One transaction per cycle in, one per cycle out, while pos_ch does not stall.
//  The pipeline depth is set by the chain of six CORDIC passes and seven
//  four-stage multipliers.
//  rst_n clears the valid bits and the delay lines; multiplier, CORDIC and
//  output registers are not reset.
//  A stall on pos_ch freezes the whole pipeline; day_ch.ready drops with it.
// ----------------------------------------------------------------------------
module sun_position_ephemeris_unit #(
    parameter int ANGLE_BITS    = spe_pkg::ANGLE_BITS_DEF,
    parameter int DAY_FRAC_BITS = spe_pkg::DAY_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = spe_pkg::CORDIC_STAGES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    spe_day_if.sink          day_ch,
    spe_pos_if.source        pos_ch
);

    localparam logic [63:0] AMASK = spe_pkg::amask(ANGLE_BITS);
    localparam int L     = spe_pkg::MUL_LAT;
    localparam int R     = CORDIC_STAGES + 2;
    localparam int V     = CORDIC_STAGES + 1;
    localparam int T_LIN = L + 1;
    localparam int TA    = T_LIN + R;
    localparam int TB    = TA + L;
    localparam int TC    = TB + L;
    localparam int TD    = TC + L;
    localparam int TE    = TD + 1;
    localparam int TF    = TE + R;
    localparam int TBB   = T_LIN + 5 * L + 1;
    localparam int TG    = TF + L;
    localparam int TH    = TG + V;
    localparam int TI    = TH + 1;
    localparam int TJ    = TI + R;
    localparam int TK    = TJ + L;
    localparam int TL    = TK + V;
    localparam int TM    = TL + L;
    localparam int TN    = TM + V;

    logic        adv;
    logic        vld_out;
    logic [63:0] d64;
    logic [63:0] pw, pm, po, pe;
    logic [63:0] w_reg, m_reg, obl_reg, e_reg, l_reg;
    logic [63:0] w_next, m_next;
    logic [63:0] cm, sm, e_a, esm, ecm, one_ecm, uu, de, m_d;
    logic [63:0] ecc_reg, ce, se, e_f, x_reg, x_g;
    logic [63:0] u1, u1_a, u1_b, u1_c, u1_e, u2, u3, u4, u5, u2_d, u3_d, u4_d;
    logic [63:0] b_reg, b_f, y, v, w_h, lon_reg, obl_i;
    logic [63:0] cl, sl, co, so, yq, zq, cl_k, ra_raw, g, mag, zq_m, ra_n;
    logic [63:0] decl_raw, decl_m, l_n, ut64, sub;
    logic [DAY_FRAC_BITS-1:0] ut;
    logic [31:0] ra_out_reg, decl_out_reg, sub_out_reg;

    assign adv          = !vld_out || pos_ch.ready;
    assign day_ch.ready = adv;
    assign d64          = {{28{day_ch.day_offset[35]}}, day_ch.day_offset};

    // linear terms in the day offset
    spe_mul #(.SH(DAY_FRAC_BITS))     u_mul_w (.clk, .en(adv), .a(d64),
                                               .b(spe_pkg::C_KW), .p(pw));
    spe_mul #(.SH(DAY_FRAC_BITS))     u_mul_m (.clk, .en(adv), .a(d64),
                                               .b(spe_pkg::C_KM), .p(pm));
    spe_mul #(.SH(DAY_FRAC_BITS))     u_mul_o (.clk, .en(adv), .a(d64),
                                               .b(spe_pkg::C_KO), .p(po));
    spe_mul #(.SH(DAY_FRAC_BITS + 4)) u_mul_e (.clk, .en(adv), .a(d64),
                                               .b(spe_pkg::C_KE), .p(pe));

    assign w_next = (spe_pkg::C_W0 + pw) & AMASK;
    assign m_next = (spe_pkg::C_M0 + pm) & AMASK;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg   <= w_next;
            m_reg   <= m_next;
            l_reg   <= w_next + m_next;
            obl_reg <= (spe_pkg::C_O0 - po) & AMASK;
            e_reg   <= spe_pkg::C_E0 - pe;
        end
    end

    // eccentric anomaly, one step
    spe_rot #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_rot_m (
        .clk, .en(adv), .ang(m_reg), .c(cm), .s(sm));
    spe_dly #(.W(64), .D(TA - T_LIN)) u_dly_ea (.clk, .rst_n, .en(adv), .d(e_reg), .q(e_a));
    spe_mul u_mul_esm (.clk, .en(adv), .a(e_a), .b(sm), .p(esm));
    spe_mul u_mul_ecm (.clk, .en(adv), .a(e_a), .b(cm), .p(ecm));
    assign one_ecm = spe_pkg::ONE + ecm;
    spe_mul u_mul_u (.clk, .en(adv), .a(esm), .b(one_ecm), .p(uu));
    spe_mul u_mul_de (.clk, .en(adv), .a(uu), .b(spe_pkg::INV2PI), .p(de));
    spe_dly #(.W(64), .D(TD - T_LIN)) u_dly_md (.clk, .rst_n, .en(adv), .d(m_reg), .q(m_d));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ecc_reg <= (m_d + (de & AMASK)) & AMASK;
        end
    end

    spe_rot #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_rot_ecc (
        .clk, .en(adv), .ang(ecc_reg), .c(ce), .s(se));

    // sqrt(1 - e^2) by series in u = e^2
    spe_mul u_mul_u1 (.clk, .en(adv), .a(e_reg), .b(e_reg), .p(u1));
    spe_dly #(.W(64), .D(L)) u_dly_u1a (.clk, .rst_n, .en(adv), .d(u1), .q(u1_a));
    spe_dly #(.W(64), .D(L)) u_dly_u1b (.clk, .rst_n, .en(adv), .d(u1_a), .q(u1_b));
    spe_dly #(.W(64), .D(L)) u_dly_u1c (.clk, .rst_n, .en(adv), .d(u1_b), .q(u1_c));
    spe_dly #(.W(64), .D(L)) u_dly_u1e (.clk, .rst_n, .en(adv), .d(u1_c), .q(u1_e));
    spe_mul u_mul_u2 (.clk, .en(adv), .a(u1), .b(u1), .p(u2));
    spe_mul u_mul_u3 (.clk, .en(adv), .a(u2), .b(u1_a), .p(u3));
    spe_mul u_mul_u4 (.clk, .en(adv), .a(u3), .b(u1_b), .p(u4));
    spe_mul u_mul_u5 (.clk, .en(adv), .a(u4), .b(u1_c), .p(u5));
    spe_dly #(.W(64), .D(3 * L)) u_dly_u2 (.clk, .rst_n, .en(adv), .d(u2), .q(u2_d));
    spe_dly #(.W(64), .D(2 * L)) u_dly_u3 (.clk, .rst_n, .en(adv), .d(u3), .q(u3_d));
    spe_dly #(.W(64), .D(L)) u_dly_u4 (.clk, .rst_n, .en(adv), .d(u4), .q(u4_d));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg <= spe_pkg::ONE - (u1_e >> 1) - (u2_d >> 3) - (u3_d >> 4)
                   - ((u4_d + (u4_d << 2)) >> 7) - (((u5 << 3) - u5) >> 8);
        end
    end

    spe_dly #(.W(64), .D(TF - TBB)) u_dly_bf (.clk, .rst_n, .en(adv), .d(b_reg), .q(b_f));

    // true anomaly
    spe_dly #(.W(64), .D(TF - TA)) u_dly_ef (.clk, .rst_n, .en(adv), .d(e_a), .q(e_f));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= ce - e_f;
        end
    end

    spe_dly #(.W(64), .D(L - 1)) u_dly_xg (.clk, .rst_n, .en(adv), .d(x_reg), .q(x_g));
    spe_mul u_mul_y (.clk, .en(adv), .a(se), .b(b_f), .p(y));
    spe_vec #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_vec_v (
        .clk, .en(adv), .x(x_g), .y(y), .ang(v), .mag());

    spe_dly #(.W(64), .D(TH - T_LIN)) u_dly_wh (.clk, .rst_n, .en(adv), .d(w_reg), .q(w_h));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lon_reg <= (v + w_h) & AMASK;
        end
    end

    // ecliptic to equatorial
    spe_dly #(.W(64), .D(TI - T_LIN)) u_dly_obl (.clk, .rst_n, .en(adv), .d(obl_reg),
                                                .q(obl_i));
    spe_rot #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_rot_lon (
        .clk, .en(adv), .ang(lon_reg), .c(cl), .s(sl));
    spe_rot #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_rot_obl (
        .clk, .en(adv), .ang(obl_i), .c(co), .s(so));
    spe_mul u_mul_yq (.clk, .en(adv), .a(sl), .b(co), .p(yq));
    spe_mul u_mul_zq (.clk, .en(adv), .a(sl), .b(so), .p(zq));
    spe_dly #(.W(64), .D(L)) u_dly_cl (.clk, .rst_n, .en(adv), .d(cl), .q(cl_k));

    spe_vec #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_vec_ra (
        .clk, .en(adv), .x(cl_k), .y(yq), .ang(ra_raw), .mag(g));
    spe_mul u_mul_mag (.clk, .en(adv), .a(g), .b(spe_pkg::C_KINV), .p(mag));
    spe_dly #(.W(64), .D(TM - TK)) u_dly_zq (.clk, .rst_n, .en(adv), .d(zq), .q(zq_m));
    spe_dly #(.W(64), .D(TN - TL)) u_dly_ra (.clk, .rst_n, .en(adv), .d(ra_raw & AMASK),
                                            .q(ra_n));
    spe_vec #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_vec_dec (
        .clk, .en(adv), .x(mag), .y(zq_m), .ang(decl_raw), .mag());

    // sub-solar longitude
    spe_dly #(.W(64), .D(TN - T_LIN)) u_dly_l (.clk, .rst_n, .en(adv), .d(l_reg), .q(l_n));
    spe_dly #(.W(DAY_FRAC_BITS), .D(TN)) u_dly_ut (
        .clk, .rst_n, .en(adv), .d(day_ch.day_offset[DAY_FRAC_BITS-1:0]), .q(ut));

    assign ut64   = {ut, {(64 - DAY_FRAC_BITS){1'b0}}};
    assign sub    = (ra_n - (l_n + spe_pkg::SIGN) - ut64) & AMASK;
    assign decl_m = decl_raw & AMASK;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ra_out_reg   <= ra_n[63:32];
            decl_out_reg <= decl_m[63:32];
            sub_out_reg  <= sub[63:32];
        end
    end

    // valid bit of each transaction, output register included
    spe_dly #(.W(1), .D(TN + 1)) u_dly_vld (.clk, .rst_n, .en(adv), .d(day_ch.valid),
                                           .q(vld_out));

    assign pos_ch.valid              = vld_out;
    assign pos_ch.right_ascension    = ra_out_reg;
    assign pos_ch.declination        = decl_out_reg;
    assign pos_ch.subsolar_longitude = sub_out_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sun_position_ephemeris_unit. A bit-exact fixed-point
// predictor computes right ascension, declination and sub-solar longitude
// for every accepted day offset. Each output transaction is compared with
// the oldest prediction. Stimulus runs directed corners, then random offsets
// with random idling on both sides, then a long output stall, then a full
// rate stream.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          STAGES   = spe_pkg::CORDIC_STAGES_DEF;
    localparam int          FRAC     = spe_pkg::DAY_FRAC_BITS_DEF;
    localparam int          VF       = spe_pkg::VFRAC;
    localparam int          LATENCY  = 6 * STAGES + 41;
    localparam int          WDOG_MAX = 5000;
    localparam logic [63:0] AMASK    = ~64'd0 << (64 - spe_pkg::ANGLE_BITS_DEF);

    typedef struct packed {
        logic [31:0] ra;
        logic [31:0] decl;
        logic [31:0] sub;
    } sun_pos_t;

    logic clk;
    logic rst_n;

    spe_day_if day_ch ();
    spe_pos_if pos_ch ();

    sun_position_ephemeris_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .day_ch (day_ch.sink),
        .pos_ch (pos_ch.source)
    );

    sun_pos_t    pending_pos[$];
    logic [63:0] atan_tbl[STAGES];
    int          fails;
    bit          idle_en;
    int          hold_reqs;
    int          hold_seen;
    int          hold_left;
    int          stall_left;
    int          quiet_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] mshift(input logic [63:0] a, input logic [63:0] b,
                                           input int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p >> sh);
    endfunction

    function automatic logic [63:0] smul(input logic [63:0] a, input logic [63:0] b,
                                         input int sh);
        logic        neg;
        logic [63:0] r;
        neg = a[63] ^ b[63];
        if (a[63])
            a = -a;
        if (b[63])
            b = -b;
        r = mshift(a, b, sh);
        return neg ? -r : r;
    endfunction

    function automatic logic [63:0] asr(input logic [63:0] x, input int s);
        return 64'($signed(x) >>> s);
    endfunction

    task automatic rotate(input logic [63:0] ang, output logic [63:0] c,
                          output logic [63:0] s);
        logic [63:0] z;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] dx;
        logic [63:0] dy;
        logic        flip;
        z = ang;
        x = spe_pkg::C_KINV;
        y = '0;
        flip = ang[63] ^ ang[62];
        if (flip)
            z = z + spe_pkg::SIGN;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z[63])
            begin
                x = x + dx; y = y - dy; z = z + atan_tbl[i];
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - atan_tbl[i];
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endtask

    task automatic vector(input logic [63:0] xi, input logic [63:0] yi,
                          output logic [63:0] ang, output logic [63:0] mag);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] dx;
        logic [63:0] dy;
        x = xi;
        y = yi;
        z = '0;
        if (x[63])
        begin
            x = -x; y = -y; z = spe_pkg::SIGN;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (y[63])
            begin
                x = x - dx; y = y + dy; z = z - atan_tbl[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + atan_tbl[i];
            end
        end
        ang = z;
        mag = x;
    endtask

    task automatic predict_sun(input logic [35:0] day, output sun_pos_t res);
        logic [63:0] d, w, m, l, obl, e, sm, cm, u, de, ecc, se, ce, b;
        logic [63:0] u2, u3, u4, u5, x, y, v, lon, sl, cl, so, co, yq, zq;
        logic [63:0] ra, g, mag, decl, junk, ut, sub;
        d   = {{28{day[35]}}, day};
        w   = (spe_pkg::C_W0 + smul(d, spe_pkg::C_KW, FRAC)) & AMASK;
        m   = (spe_pkg::C_M0 + smul(d, spe_pkg::C_KM, FRAC)) & AMASK;
        l   = w + m;
        obl = (spe_pkg::C_O0 - smul(d, spe_pkg::C_KO, FRAC)) & AMASK;
        e   = spe_pkg::C_E0 - smul(d, spe_pkg::C_KE, FRAC + 4);
        rotate(m, cm, sm);
        u   = smul(smul(e, sm, VF), spe_pkg::ONE + smul(e, cm, VF), VF);
        de  = smul(u, spe_pkg::INV2PI, VF) & AMASK;
        ecc = (m + de) & AMASK;
        rotate(ecc, ce, se);
        u  = smul(e, e, VF);
        u2 = smul(u, u, VF);
        u3 = smul(u2, u, VF);
        u4 = smul(u3, u, VF);
        u5 = smul(u4, u, VF);
        b  = spe_pkg::ONE - (u >> 1) - (u2 >> 3) - (u3 >> 4) - ((u4 * 5) >> 7)
             - ((u5 * 7) >> 8);
        x  = ce - e;
        y  = smul(se, b, VF);
        vector(x, y, v, junk);
        lon = (v + w) & AMASK;
        rotate(lon, cl, sl);
        rotate(obl, co, so);
        yq = smul(sl, co, VF);
        zq = smul(sl, so, VF);
        vector(cl, yq, ra, g);
        ra  = ra & AMASK;
        mag = smul(g, spe_pkg::C_KINV, VF);
        vector(mag, zq, decl, junk);
        decl = decl & AMASK;
        ut   = (d & ((64'd1 << FRAC) - 1)) << (64 - FRAC);
        sub  = (ra - (l + spe_pkg::SIGN) - ut) & AMASK;
        res.ra   = ra[63:32];
        res.decl = decl[63:32];
        res.sub  = sub[63:32];
    endtask

    task automatic build_atan();
        logic [63:0] s;
        logic [63:0] t;
        int          sh;
        atan_tbl[0] = 64'd1 << 61;
        for (int i = 1; i < STAGES; i++)
        begin
            s = '0;
            for (int k = 0; k < 32; k++)
            begin
                sh = i * (2 * k + 1);
                if (sh < 64)
                begin
                    t = (spe_pkg::SIGN >> sh) / 64'(2 * k + 1);
                    s = (k & 1) ? s - t : s + t;
                end
            end
            atan_tbl[i] = mshift(s, spe_pkg::INV2PI, 63) & AMASK;
        end
    endtask

    // ---------------- driving ----------------
    task automatic send_day(input logic [35:0] day);
        sun_pos_t exp_pos;
        int       gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            day_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        day_ch.valid      <= 1'b1;
        day_ch.day_offset <= day;
        predict_sun(day, exp_pos);
        do
            @(posedge clk);
        while (!day_ch.ready);
        pending_pos.push_back(exp_pos);
    endtask

    task automatic go_idle();
        day_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // realistic span: the full 16-bit signed day range (about +-89 years),
    // random fraction
    function automatic logic [35:0] near_day();
        logic [35:0] dd;
        dd = 36'($urandom_range(0, 65535)) - 36'd32768;
        return {dd[15:0], 20'($urandom)};
    endfunction

    function automatic logic [35:0] any_day();
        return {4'($urandom), 32'($urandom)};
    endfunction

    task automatic test_directed();
        send_day(36'd0);
        send_day(36'h7_FFFF_FFFF);
        send_day(36'h8_0000_0000);
        send_day(36'hF_FFFF_FFFF);
        send_day(36'd1);
        send_day(36'd1 << FRAC);
        send_day(-(36'd1 << FRAC));
        send_day(36'd1 << (FRAC - 1));
        send_day(-(36'd1 << (FRAC - 1)));
        send_day(36'h0_0000_FFFF);
        send_day(36'h0_FFF0_0000);
        send_day(36'h5_5555_5555);
        send_day(36'hA_AAAA_AAAA);
        send_day(36'd9131 << FRAC);
        send_day(-(36'd36525 << FRAC));
        send_day(36'd182 << FRAC | 36'h8_0000);
        go_idle();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_day(($urandom_range(0, 2) == 0) ? any_day() : near_day());
        go_idle();
    endtask

    task automatic test_output_stall(input int n);
        idle_en = 1'b0;
        hold_reqs++;
        for (int i = 0; i < n; i++)
            send_day(near_day());
        go_idle();
        idle_en = 1'b1;
    endtask

    task automatic test_stream(input int n);
        idle_en = 1'b0;
        for (int i = 0; i < n; i++)
            send_day(($urandom_range(0, 1) == 0) ? any_day() : near_day());
        go_idle();
    endtask

    // ---------------- output side ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_ch.ready <= 1'b0;
            hold_seen    <= 0;
            hold_left    <= 0;
            stall_left   <= 0;
        end
        else if (hold_seen != hold_reqs)
        begin
            hold_seen    <= hold_reqs;
            hold_left    <= 600;
            pos_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            pos_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            pos_ch.ready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            stall_left   <= $urandom_range(0, 4);
            pos_ch.ready <= 1'b0;
        end
        else
        begin
            pos_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        sun_pos_t want;
        if (rst_n && pos_ch.valid && pos_ch.ready)
        begin
            if (pending_pos.size() == 0)
            begin
                $display("%0t: unexpected transaction ra=%h decl=%h sub=%h", $time,
                         pos_ch.right_ascension, pos_ch.declination,
                         pos_ch.subsolar_longitude);
                fails++;
            end
            else
            begin
                want = pending_pos.pop_front();
                if (pos_ch.right_ascension !== want.ra)
                begin
                    $display("%0t: right_ascension expected %h actual %h", $time,
                             want.ra, pos_ch.right_ascension);
                    fails++;
                end
                if (pos_ch.declination !== want.decl)
                begin
                    $display("%0t: declination expected %h actual %h", $time,
                             want.decl, pos_ch.declination);
                    fails++;
                end
                if (pos_ch.subsolar_longitude !== want.sub)
                begin
                    $display("%0t: subsolar_longitude expected %h actual %h", $time,
                             want.sub, pos_ch.subsolar_longitude);
                    fails++;
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (day_ch.valid && day_ch.ready) || (pos_ch.valid && pos_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("%0t: watchdog timeout, %0d transactions outstanding", $time,
                     pending_pos.size());
            $display("sun_position_ephemeris_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        fails             = 0;
        idle_en           = 1'b1;
        hold_reqs         = 0;
        quiet_cycles      = 0;
        rst_n             = 1'b0;
        day_ch.valid      = 1'b0;
        day_ch.day_offset = '0;
        build_atan();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(1200);
        test_output_stall(300);
        test_stream(400);

        while (pending_pos.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (fails == 0)
            $display("sun_position_ephemeris_unit regression: pass");
        else
            $display("sun_position_ephemeris_unit regression: fail");
        $finish;
    end

endmodule
